// ===== sv/podo_pkg.sv =====
// ----------------------------------------------------------------------------
// podo_pkg
// Shared widths, CORDIC constants and the request and response types of the
// CORDIC engine used by the planar odometry integrator.
// ----------------------------------------------------------------------------
package podo_pkg;

    localparam int VEL_W     = 16;
    localparam int TIME_W    = 16;
    localparam int POS_OUT_W = 40;
    localparam int Q15_W     = 16;
    localparam int ANGLE_W   = 32;
    localparam int CORD_W    = 34;
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = $clog2(TABLE_LEN);

    // Infinite-product CORDIC gain in Q4.30.
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // One eighth of a turn, used to center the quadrant fold.
    localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;

    // 2^32 / (2 pi), rounded: radians to binary angle.
    localparam int YAW_SCALE = 683565276;

    // Arctangent of 2^-i as a 32 bit binary angle.
    localparam logic [ANGLE_W-1:0] ATAN_BAM [TABLE_LEN] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct packed {
        logic               load;
        logic [ANGLE_W-1:0] angle;
    } cord_req_t;

    typedef struct packed {
        logic                     busy;
        logic signed [CORD_W-1:0] cos_val;
        logic signed [CORD_W-1:0] sin_val;
    } cord_rsp_t;

endpackage

// ===== sv/podo_cordic.sv =====
// ----------------------------------------------------------------------------
// podo_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, giving the
// Q4.30 cosine and sine of a 32 bit binary angle.
// ----------------------------------------------------------------------------
module podo_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  podo_pkg::cord_req_t req,
    output podo_pkg::cord_rsp_t rsp
);
    import podo_pkg::*;

    localparam int STEPS_EFF = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W    = (STEPS_EFF > 1) ? $clog2(STEPS_EFF) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_EFF - 1);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic                     busy_reg, busy_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [1:0]               quad_reg, quad_next;
    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    logic signed [CORD_W-1:0] z_reg, z_next;
    logic [ANGLE_W-1:0]       ang_biased;
    logic [ANGLE_W-1:0]       ang_folded;
    logic signed [CORD_W-1:0] x_sh;
    logic signed [CORD_W-1:0] y_sh;
    logic signed [CORD_W-1:0] atan_val;

    assign ang_biased = req.angle + EIGHTH_TURN;
    assign ang_folded = req.angle - {ang_biased[ANGLE_W-1 -: 2], {(ANGLE_W-2){1'b0}}};
    assign x_sh       = x_reg >>> step_reg;
    assign y_sh       = y_reg >>> step_reg;
    assign atan_val   = {{(CORD_W-ANGLE_W){1'b0}}, ATAN_BAM[IDX_W'(step_reg)]};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quad_next = quad_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (req.load)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quad_next = ang_biased[ANGLE_W-1 -: 2];
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = CORD_W'(signed'(ang_folded));
        end
        else if (busy_reg)
        begin
            // Rotate toward zero residual angle.
            if (!z_reg[CORD_W-1])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_val;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_val;
            end
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // Undo the quarter-turn fold.
    always_comb
    begin
        rsp.busy = busy_reg;
        case (quad_reg)
            QUAD_0:
            begin
                rsp.cos_val = x_reg;
                rsp.sin_val = y_reg;
            end
            QUAD_1:
            begin
                rsp.cos_val = -y_reg;
                rsp.sin_val = x_reg;
            end
            QUAD_2:
            begin
                rsp.cos_val = -x_reg;
                rsp.sin_val = -y_reg;
            end
            QUAD_3:
            begin
                rsp.cos_val = y_reg;
                rsp.sin_val = -x_reg;
            end
            default:
            begin
                rsp.cos_val = x_reg;
                rsp.sin_val = y_reg;
            end
        endcase
    end

endmodule

// ===== sv/planar_odometry_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit
// Dead-reckoning odometry in fixed point. Each sample item carries body-frame
// forward and sideways velocity, yaw rate and elapsed time. The block rotates
// the velocity by the old heading, integrates x and y (saturating), advances
// the wrapping heading and returns the pose with its yaw quaternion.
// The sample channel is taken when sample_valid and sample_ready are both
// high; sample_ready is high whenever no item is in work. The pose item sits in
// an output register until pose_ready takes it; the next sample may be taken
// meanwhile, and its own result waits in the last cycle until the register is
// free. The time from acceptance to pose_valid is set by the CORDIC pass on the
// old heading followed by two 16 bit serial multiplies (velocity by cosine and
// sine, then by elapsed time); the heading multiply and the quaternion CORDIC
// pass run alongside them. Reset clears the pose to zero.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_unit #(
    parameter int POSITION_BITS = 40,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [podo_pkg::VEL_W-1:0]     forward_velocity,
    input  logic signed [podo_pkg::VEL_W-1:0]     sideways_velocity,
    input  logic signed [podo_pkg::VEL_W-1:0]     yaw_rate,
    input  logic        [podo_pkg::TIME_W-1:0]    elapsed_time,
    output logic                                 pose_valid,
    input  logic                                 pose_ready,
    output logic signed [podo_pkg::POS_OUT_W-1:0] position_x,
    output logic signed [podo_pkg::POS_OUT_W-1:0] position_y,
    output logic        [podo_pkg::ANGLE_W-1:0]   heading_angle,
    output logic signed [podo_pkg::Q15_W-1:0]     quat_z,
    output logic signed [podo_pkg::Q15_W-1:0]     quat_w
);
    import podo_pkg::*;

    localparam int STEPS_EFF = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // Cycle schedule, counted from the first cycle after acceptance.
    localparam int CS_CYC    = STEPS_EFF;
    localparam int B1_FIRST  = CS_CYC + 1;
    localparam int B1_LAST   = CS_CYC + VEL_W;
    localparam int B2_FIRST  = B1_LAST + 1;
    localparam int B2_LAST   = B1_LAST + TIME_W;
    localparam int HK_LAST   = VEL_W - 1;
    localparam int PH_FIRST  = VEL_W;
    localparam int PH_LAST   = VEL_W + TIME_W - 1;
    localparam int HEAD_CYC  = VEL_W + TIME_W;
    localparam int LAST_CYC  = B2_LAST + 1;
    localparam int CYC_W     = $clog2(LAST_CYC + 1);

    localparam int PROD_W    = CORD_W + VEL_W - 2;
    localparam int TERM_W    = CORD_W + 2;
    localparam int FULL_W    = 64;
    localparam int HK_W      = 31 + VEL_W;
    localparam int POS_SHIFT = 38;
    localparam int D_W       = FULL_W - POS_SHIFT;
    localparam int Q15_SHIFT = 15;

    localparam logic signed [HK_W-1:0]   YAW_K      = HK_W'(YAW_SCALE);
    localparam logic signed [FULL_W-1:0] POS_HALF   = FULL_W'(64'h20_0000_0000);
    localparam logic signed [FULL_W-1:0] HEAD_HALF  = FULL_W'(64'h8000_0000);
    localparam logic signed [CORD_W:0]   Q15_HALF   = (CORD_W+1)'(16384);
    localparam logic signed [CORD_W:0]   Q15_MAX    = (CORD_W+1)'(32767);
    localparam logic signed [CORD_W:0]   Q15_MIN    = -(CORD_W+1)'(32768);
    localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

    function automatic logic signed [POSITION_BITS-1:0] sat_step(
        input logic signed [POSITION_BITS-1:0] acc,
        input logic signed [D_W-1:0]           d
    );
        logic signed [POSITION_BITS:0] sum;
        sum = (POSITION_BITS+1)'(acc) + (POSITION_BITS+1)'(d);
        if (sum[POSITION_BITS] != sum[POSITION_BITS-1])
        begin
            return sum[POSITION_BITS] ? POS_MIN : POS_MAX;
        end
        return sum[POSITION_BITS-1:0];
    endfunction

    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W:0] t;
        t = ((CORD_W+1)'(v) + Q15_HALF) >>> Q15_SHIFT;
        if (t > Q15_MAX)
        begin
            t = Q15_MAX;
        end
        else if (t < Q15_MIN)
        begin
            t = Q15_MIN;
        end
        return t[Q15_W-1:0];
    endfunction

    logic                     busy_reg, busy_next;
    logic [CYC_W-1:0]         cyc_reg, cyc_next;
    logic                     pose_valid_reg, pose_valid_next;
    logic [ANGLE_W-1:0]       heading_reg, heading_next;
    logic signed [POSITION_BITS-1:0] pos_x_reg, pos_x_next;
    logic signed [POSITION_BITS-1:0] pos_y_reg, pos_y_next;

    logic [VEL_W-1:0]         vf_sh_reg, vs_sh_reg, wz_sh_reg;
    logic [TIME_W-1:0]        dt_h_sh_reg, dt_p_sh_reg;
    logic signed [CORD_W-1:0] c_reg, s_reg;
    logic signed [PROD_W-1:0] acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic signed [FULL_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [HK_W-1:0]   hk_reg, hk_next;
    logic signed [FULL_W-1:0] ph_reg, ph_next;

    logic signed [POS_OUT_W-1:0] out_x_reg, out_y_reg;
    logic [ANGLE_W-1:0]          out_head_reg;
    logic signed [Q15_W-1:0]     out_qz_reg, out_qw_reg;

    logic accept, finish;
    logic hk_act, ph_act, b1_act, b2_act, cs_cap, head_cyc, last_cyc;
    logic b1_first, b2_first, ph_first;

    logic signed [CORD_W-1:0] pick_fc, pick_fs, pick_sc, pick_ss;
    logic signed [TERM_W-1:0] raw_a, raw_b, term_a, term_b;
    logic signed [HK_W-1:0]   term_k;
    logic signed [FULL_W-1:0] add_px, add_py, add_ph;
    logic signed [FULL_W-1:0] ph_round, px_round, py_round;
    logic [ANGLE_W-1:0]       heading_new;
    logic signed [D_W-1:0]    d_x, d_y;
    logic signed [FULL_W-1:0] ext_x, ext_y;

    cord_req_t cor_req;
    cord_rsp_t cor_rsp;

    podo_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (cor_req),
        .rsp  (cor_rsp)
    );

    assign sample_ready = !busy_reg;
    assign accept       = sample_valid && !busy_reg;

    assign hk_act   = busy_reg && (cyc_reg <= CYC_W'(HK_LAST));
    assign ph_act   = busy_reg && (cyc_reg >= CYC_W'(PH_FIRST)) && (cyc_reg <= CYC_W'(PH_LAST));
    assign ph_first = cyc_reg == CYC_W'(PH_FIRST);
    assign cs_cap   = busy_reg && (cyc_reg == CYC_W'(CS_CYC));
    assign b1_act   = busy_reg && (cyc_reg >= CYC_W'(B1_FIRST)) && (cyc_reg <= CYC_W'(B1_LAST));
    assign b1_first = cyc_reg == CYC_W'(B1_FIRST);
    assign b2_act   = busy_reg && (cyc_reg >= CYC_W'(B2_FIRST)) && (cyc_reg <= CYC_W'(B2_LAST));
    assign b2_first = cyc_reg == CYC_W'(B2_FIRST);
    assign head_cyc = busy_reg && (cyc_reg == CYC_W'(HEAD_CYC));
    assign last_cyc = busy_reg && (cyc_reg == CYC_W'(LAST_CYC));
    assign finish   = last_cyc && (!pose_valid_reg || pose_ready);

    // Velocity times cosine and sine, one velocity bit per cycle, MSB first.
    // The first bit is the sign bit and carries negative weight.
    assign pick_fc = vf_sh_reg[VEL_W-1] ? c_reg : '0;
    assign pick_fs = vf_sh_reg[VEL_W-1] ? s_reg : '0;
    assign pick_sc = vs_sh_reg[VEL_W-1] ? c_reg : '0;
    assign pick_ss = vs_sh_reg[VEL_W-1] ? s_reg : '0;
    assign raw_a   = TERM_W'(pick_fc) - TERM_W'(pick_ss);
    assign raw_b   = TERM_W'(pick_fs) + TERM_W'(pick_sc);
    assign term_a  = b1_first ? -raw_a : raw_a;
    assign term_b  = b1_first ? -raw_b : raw_b;
    assign acc_a_next = (b1_first ? PROD_W'(0) : (acc_a_reg <<< 1)) + PROD_W'(term_a);
    assign acc_b_next = (b1_first ? PROD_W'(0) : (acc_b_reg <<< 1)) + PROD_W'(term_b);

    // Rotated velocity times elapsed time, one time bit per cycle.
    assign add_px  = dt_p_sh_reg[TIME_W-1] ? FULL_W'(acc_a_reg) : FULL_W'(0);
    assign add_py  = dt_p_sh_reg[TIME_W-1] ? FULL_W'(acc_b_reg) : FULL_W'(0);
    assign px_next = (b2_first ? FULL_W'(0) : (px_reg <<< 1)) + add_px;
    assign py_next = (b2_first ? FULL_W'(0) : (py_reg <<< 1)) + add_py;

    // Heading: yaw rate times the scale, then times elapsed time.
    assign term_k  = wz_sh_reg[VEL_W-1] ? ((cyc_reg == '0) ? -YAW_K : YAW_K) : HK_W'(0);
    assign hk_next = ((cyc_reg == '0) ? HK_W'(0) : (hk_reg <<< 1)) + term_k;
    assign add_ph  = dt_h_sh_reg[TIME_W-1] ? FULL_W'(hk_reg) : FULL_W'(0);
    assign ph_next = (ph_first ? FULL_W'(0) : (ph_reg <<< 1)) + add_ph;

    assign ph_round    = ph_reg + HEAD_HALF;
    assign heading_new = heading_reg + ph_round[FULL_W-1 -: ANGLE_W];

    assign px_round = px_reg + POS_HALF;
    assign py_round = py_reg + POS_HALF;
    assign d_x      = px_round[FULL_W-1:POS_SHIFT];
    assign d_y      = py_round[FULL_W-1:POS_SHIFT];
    assign ext_x    = FULL_W'(pos_x_next);
    assign ext_y    = FULL_W'(pos_y_next);

    // The first pass works on the old heading, the second on half the new one.
    assign cor_req.load  = accept || head_cyc;
    assign cor_req.angle = accept ? heading_reg : {1'b0, heading_new[ANGLE_W-1:1]};

    always_comb
    begin
        busy_next       = busy_reg;
        cyc_next        = cyc_reg;
        heading_next    = heading_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        pose_valid_next = pose_valid_reg && !pose_ready;
        if (accept)
        begin
            busy_next = 1'b1;
            cyc_next  = '0;
        end
        else if (busy_reg && !last_cyc)
        begin
            cyc_next = cyc_reg + CYC_W'(1);
        end
        if (head_cyc)
        begin
            heading_next = heading_new;
        end
        if (finish)
        begin
            busy_next       = 1'b0;
            pose_valid_next = 1'b1;
            pos_x_next      = sat_step(pos_x_reg, d_x);
            pos_y_next      = sat_step(pos_y_reg, d_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cyc_reg        <= '0;
            pose_valid_reg <= 1'b0;
            heading_reg    <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            cyc_reg        <= cyc_next;
            pose_valid_reg <= pose_valid_next;
            heading_reg    <= heading_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vf_sh_reg   <= forward_velocity;
            vs_sh_reg   <= sideways_velocity;
            wz_sh_reg   <= yaw_rate;
            dt_h_sh_reg <= elapsed_time;
            dt_p_sh_reg <= elapsed_time;
        end
        else
        begin
            if (hk_act)
            begin
                wz_sh_reg <= wz_sh_reg << 1;
                hk_reg    <= hk_next;
            end
            if (ph_act)
            begin
                dt_h_sh_reg <= dt_h_sh_reg << 1;
                ph_reg      <= ph_next;
            end
            if (b1_act)
            begin
                vf_sh_reg <= vf_sh_reg << 1;
                vs_sh_reg <= vs_sh_reg << 1;
                acc_a_reg <= acc_a_next;
                acc_b_reg <= acc_b_next;
            end
            if (b2_act)
            begin
                dt_p_sh_reg <= dt_p_sh_reg << 1;
                px_reg      <= px_next;
                py_reg      <= py_next;
            end
        end
        if (cs_cap)
        begin
            c_reg <= cor_rsp.cos_val;
            s_reg <= cor_rsp.sin_val;
        end
        if (finish)
        begin
            out_x_reg    <= ext_x[POS_OUT_W-1:0];
            out_y_reg    <= ext_y[POS_OUT_W-1:0];
            out_head_reg <= heading_reg;
            out_qz_reg   <= to_q15(cor_rsp.sin_val);
            out_qw_reg   <= to_q15(cor_rsp.cos_val);
        end
    end

    assign pose_valid    = pose_valid_reg;
    assign position_x    = out_x_reg;
    assign position_y    = out_y_reg;
    assign heading_angle = out_head_reg;
    assign quat_z        = out_qz_reg;
    assign quat_w        = out_qw_reg;

    // The heading moves only at its commit cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !head_cyc |=> $stable(heading_reg))
        else $error("heading changed outside its commit cycle");

    // The CORDIC engine is never restarted in the middle of a pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cor_req.load |-> !cor_rsp.busy)
        else $error("CORDIC loaded while busy");

    // Cosine, sine and quaternion are read only from a finished pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cs_cap || last_cyc) |-> !cor_rsp.busy)
        else $error("CORDIC result read before the pass finished");

    // A new pose item appears only from a completed item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid_reg) |-> $past(finish))
        else $error("pose item raised without a finished item");

endmodule
